/* rtl/core/dept_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dept_pkg
// Shared sizes, request codes and controller states of the dirty entry /
// log position table.
// ----------------------------------------------------------------------------
package dept_pkg;

  // table geometry
  localparam int MaxEntries = 64;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = IdxW + 1;
  localparam int CfgW       = 7;
  localparam int PosW       = 31;
  localparam int ActW       = 2;

  // request codes
  typedef enum logic [ActW-1:0] {
    ACT_MARK   = 2'd0,
    ACT_SYNC   = 2'd1,
    ACT_REPLAY = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

endpackage

/* rtl/core/dirty_entry_position_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_entry_position_table
// Per-entry dirty mark and recorded log position, with mark, sync, replay
// check and first-dirty query requests.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (action_i, entry_index_i, position_i) is taken on a rising
//   edge with start high and busy low. Exactly one result beat follows,
//   shown on the result ports for one cycle with done_o high; the receiver
//   has no back-pressure and must take it then.
//   Mark, sync and replay requests, and any out-of-range index: the position
//   memory read is registered at accept, the controller passes through ST_EXEC
//   and the result beat is registered from there. A new request may be taken in
//   the done cycle, but not before.
//   First-dirty query: the scan reads one memory entry per cycle over the N
//   entries in use; with a count of zero the query goes through ST_EXEC.
//   entry_count is written through cfg_we_i / cfg_wdata_i; the user must do so
//   only while idle, the block does not enforce it. Saturated to 64 entries.
//   Reset clears all dirty marks and makes every recorded position read as
//   zero (per-entry valid flops), sets the count to 64; no clearing pass.
// ----------------------------------------------------------------------------
module dirty_entry_position_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         cfg_we_i,
  input  logic [dept_pkg::CfgW-1:0]    cfg_wdata_i,
  // request
  input  logic                         start,
  output logic                         busy,
  input  logic [dept_pkg::ActW-1:0]    action_i,
  input  logic [dept_pkg::IdxW-1:0]    entry_index_i,
  input  logic [dept_pkg::PosW-1:0]    position_i,
  // result
  output logic                         done_o,
  output logic                         was_dirty_o,
  output logic                         replay_needed_o,
  output logic [dept_pkg::PosW-1:0]    first_position_o,
  output logic                         any_dirty_o,
  output logic                         entry_error_o
);
  import dept_pkg::*;

  state_e                state_q, state_d;
  logic [CfgW-1:0]       cfg_q;
  logic [CntW-1:0]       cnt_eff;
  action_e               act_q;
  logic [PosW-1:0]       pos_q;

  logic [MaxEntries-1:0] dirty_q;
  logic [MaxEntries-1:0] pv_q;

  logic [PosW-1:0]       mem [MaxEntries];
  logic [PosW-1:0]       rd_data_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [IdxW-1:0]       rd_addr;

  logic [PosW-1:0]       min_q, min_d;
  logic                  any_q, any_d;

  logic                  accept;
  logic                  is_query;
  logic                  cnt_zero;
  logic                  last_entry;
  logic [PosW-1:0]       cur_pos;
  logic                  cur_dirty;
  logic                  idx_err;

  logic                  mem_we;
  logic                  dirty_set;
  logic                  dirty_clr;

  logic                  done_d, done_q;
  logic                  was_dirty_d, was_dirty_q;
  logic                  replay_d, replay_q;
  logic [PosW-1:0]       first_d, first_q;
  logic                  any_out_d, any_out_q;
  logic                  err_d, err_q;

  // handshake and count
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign is_query = (action_e'(action_i) == ACT_QUERY);
  assign cnt_eff  = (cfg_q > CfgW'(MaxEntries)) ? CntW'(MaxEntries) : CntW'(cfg_q);
  assign cnt_zero = (cnt_eff == '0);

  // data of the entry read last cycle
  assign cur_pos    = pv_q[rd_idx_q] ? rd_data_q : '0;
  assign cur_dirty  = dirty_q[rd_idx_q];
  assign idx_err    = ({1'b0, rd_idx_q} >= cnt_eff);
  assign last_entry = ({1'b0, rd_idx_q} == (cnt_eff - CntW'(1)));

  // read address: request index at accept (entry 0 for a query), next entry while scanning
  always_comb begin
    if (state_q == ST_SCAN) begin
      rd_addr = rd_idx_q + IdxW'(1);
    end else if (is_query) begin
      rd_addr = '0;
    end else begin
      rd_addr = entry_index_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (is_query && !cnt_zero) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (last_entry) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    mem_we      = 1'b0;
    dirty_set   = 1'b0;
    dirty_clr   = 1'b0;
    done_d      = 1'b0;
    was_dirty_d = 1'b0;
    replay_d    = 1'b0;
    first_d     = '0;
    any_out_d   = 1'b0;
    err_d       = 1'b0;
    min_d       = min_q;
    any_d       = any_q;
    unique case (state_q)
      ST_IDLE: begin
        min_d = '0;
        any_d = 1'b0;
      end
      ST_EXEC: begin
        done_d = 1'b1;
        if (act_q != ACT_QUERY) begin
          err_d = idx_err;
          if (!idx_err) begin
            case (act_q)
              ACT_MARK: begin
                was_dirty_d = cur_dirty;
                dirty_set   = 1'b1;
              end
              ACT_SYNC: begin
                dirty_clr = 1'b1;
                mem_we    = 1'b1;
              end
              ACT_REPLAY: begin
                replay_d = cur_dirty && (cur_pos <= pos_q);
              end
              default: begin
                replay_d = 1'b0;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (cur_dirty && (!any_q || (cur_pos < min_q))) begin
          min_d = cur_pos;
        end
        any_d = any_q || cur_dirty;
        if (last_entry) begin
          done_d    = 1'b1;
          first_d   = min_d;
          any_out_d = any_d;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // position memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[rd_idx_q] <= pos_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= CfgW'(MaxEntries);
      dirty_q <= '0;
      pv_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (dirty_set) begin
        dirty_q[rd_idx_q] <= 1'b1;
      end
      if (dirty_clr) begin
        dirty_q[rd_idx_q] <= 1'b0;
        pv_q[rd_idx_q]    <= 1'b1;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_addr;
    min_q       <= min_d;
    any_q       <= any_d;
    was_dirty_q <= was_dirty_d;
    replay_q    <= replay_d;
    first_q     <= first_d;
    any_out_q   <= any_out_d;
    err_q       <= err_d;
    if (accept) begin
      act_q <= action_e'(action_i);
      pos_q <= position_i;
    end
  end

  assign done_o           = done_q;
  assign was_dirty_o      = was_dirty_q;
  assign replay_needed_o  = replay_q;
  assign first_position_o = first_q;
  assign any_dirty_o      = any_out_q;
  assign entry_error_o    = err_q;

`ifndef SYNTHESIS
  // result beat only shows up once the controller is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result beat while controller busy");

  // an accepted request always occupies the controller next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted but controller not busy");

  // a rejected index reports nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && err_q) |-> (!was_dirty_q && !replay_q && !any_out_q))
    else $error("error beat carries a flag");

  // no dirty entry found means a zero position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !any_out_q) |-> (first_q == '0))
    else $error("nonzero first position without dirty entry");
`endif

endmodule

/* tb/sv/tb_dirty_entry_position_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dirty_entry_position_table
// Self-checking bench for the dirty entry / log position table. A tracker
// class mirrors the dirty marks, recorded positions and entry count. It
// predicts one result beat per accepted request and compares each done_o
// beat against the oldest prediction. A directed part covers the field
// extremes, every request type, a count of zero, a lowered count and a
// saturated count. Random phases at several entry counts follow, with
// random sender gaps in all but the last phase.
// ----------------------------------------------------------------------------
module tb_dirty_entry_position_table;
  import dept_pkg::*;

  localparam int StallLimit = 2000;
  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

  // one result beat
  typedef struct packed {
    logic            was_dirty;
    logic            replay_needed;
    logic [PosW-1:0] first_position;
    logic            any_dirty;
    logic            entry_error;
  } table_result_t;

  // shadow copy of the table plus queue of predicted result beats
  class position_table_tracker;
    bit              dirty[MaxEntries];
    logic [PosW-1:0] pos_tab[MaxEntries];
    int              entries_in_use;
    int              errors;
    table_result_t   awaited[$];

    function new();
      foreach (dirty[i]) begin
        dirty[i]   = 1'b0;
        pos_tab[i] = '0;
      end
      entries_in_use = MaxEntries;
      errors         = 0;
    endfunction

    // count register saturates at the table size
    function void set_count(logic [CfgW-1:0] v);
      entries_in_use = (int'(v) > MaxEntries) ? MaxEntries : int'(v);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(action_e act, logic [IdxW-1:0] idx, logic [PosW-1:0] pos);
      table_result_t r;
      r = '0;
      if (act == ACT_QUERY) begin
        for (int i = 0; i < entries_in_use; i++) begin
          if (dirty[i]) begin
            if (!r.any_dirty || pos_tab[i] < r.first_position) r.first_position = pos_tab[i];
            r.any_dirty = 1'b1;
          end
        end
      end else if (int'(idx) >= entries_in_use) begin
        r.entry_error = 1'b1;
      end else begin
        case (act)
          ACT_MARK: begin
            r.was_dirty = dirty[idx];
            dirty[idx]  = 1'b1;
          end
          ACT_SYNC: begin
            dirty[idx]   = 1'b0;
            pos_tab[idx] = pos;
          end
          default: begin
            r.replay_needed = dirty[idx] && (pos_tab[idx] <= pos);
          end
        endcase
      end
      awaited.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (awaited.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.was_dirty !== exp.was_dirty) begin
        $error("was_dirty: expected %0d, actual %0d", exp.was_dirty, got.was_dirty);
        errors++;
      end
      if (got.replay_needed !== exp.replay_needed) begin
        $error("replay_needed: expected %0d, actual %0d", exp.replay_needed,
               got.replay_needed);
        errors++;
      end
      if (got.first_position !== exp.first_position) begin
        $error("first_position: expected 0x%08h, actual 0x%08h", exp.first_position,
               got.first_position);
        errors++;
      end
      if (got.any_dirty !== exp.any_dirty) begin
        $error("any_dirty: expected %0d, actual %0d", exp.any_dirty, got.any_dirty);
        errors++;
      end
      if (got.entry_error !== exp.entry_error) begin
        $error("entry_error: expected %0d, actual %0d", exp.entry_error, got.entry_error);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                start;
  logic                busy;
  logic [ActW-1:0]     action_i;
  logic [IdxW-1:0]     entry_index_i;
  logic [PosW-1:0]     position_i;
  logic                done_o;
  logic                was_dirty_o;
  logic                replay_needed_o;
  logic [PosW-1:0]     first_position_o;
  logic                any_dirty_o;
  logic                entry_error_o;

  position_table_tracker tracker;
  bit                    gaps_on;
  int                    stall_cycles = 0;

  dirty_entry_position_table dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .entry_index_i    (entry_index_i),
    .position_i       (position_i),
    .done_o           (done_o),
    .was_dirty_o      (was_dirty_o),
    .replay_needed_o  (replay_needed_o),
    .first_position_o (first_position_o),
    .any_dirty_o      (any_dirty_o),
    .entry_error_o    (entry_error_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // result monitor: every done_o beat is checked
  always @(posedge clk_i) begin : result_mon
    table_result_t got;
    if (rst_ni && done_o) begin
      got = {was_dirty_o, replay_needed_o, first_position_o, any_dirty_o, entry_error_o};
      tracker.check_result(got);
    end
  end

  // watchdog: cycles with neither a request nor a result beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // one request beat, with an optional random gap ahead of it
  task automatic send(action_e act, logic [IdxW-1:0] idx, logic [PosW-1:0] pos);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        action_i      <= ActW'($urandom);
        entry_index_i <= IdxW'($urandom);
        position_i    <= PosW'($urandom);
        @(posedge clk_i);
      end
    end
    start         <= 1'b1;
    action_i      <= act;
    entry_index_i <= idx;
    position_i    <= pos;
    do @(posedge clk_i); while (busy);
    tracker.note_request(act, idx, pos);
  endtask

  // count write once the table has drained
  task automatic write_count(logic [CfgW-1:0] v);
    start <= 1'b0;
    while (tracker.pending() != 0 || busy) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_count(v);
  endtask

  // mostly small or extreme positions so replay compares land near the edge
  function automatic logic [PosW-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return PosMax;
    if (r < 65) return PosW'($urandom_range(0, 255));
    return PosW'($urandom);
  endfunction

  function automatic logic [IdxW-1:0] pick_index();
    int n;
    n = tracker.entries_in_use;
    if (n > 0 && $urandom_range(0, 99) < 88) return IdxW'($urandom_range(0, n - 1));
    return IdxW'($urandom_range(0, MaxEntries - 1));
  endfunction

  function automatic action_e pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_MARK;
    if (r < 65) return ACT_SYNC;
    if (r < 90) return ACT_REPLAY;
    return ACT_QUERY;
  endfunction

  // stimulus
  initial begin : stim
    logic [CfgW-1:0] phase_count[8];
    int              phase_items;
    tracker       = new();
    gaps_on       = 1'b1;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    action_i      = ACT_MARK;
    entry_index_i = '0;
    position_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, mark twice, extreme positions
    send(ACT_QUERY,  0, 0);
    send(ACT_MARK,   0, 0);
    send(ACT_MARK,   0, PosMax);
    send(ACT_REPLAY, 0, 0);
    send(ACT_SYNC,   63, PosMax);
    send(ACT_MARK,   63, 0);
    send(ACT_REPLAY, 63, PosMax - 1);
    send(ACT_REPLAY, 63, PosMax);
    send(ACT_SYNC,   0, 31'h5555_5555);
    send(ACT_REPLAY, 0, PosMax);
    send(ACT_MARK,   0, 0);
    send(ACT_QUERY,  0, 0);
    send(ACT_SYNC,   31, 31'h2AAA_AAAA);
    send(ACT_MARK,   31, 0);
    send(ACT_QUERY,  63, PosMax);
    // lowered count hides upper entries
    write_count(8);
    send(ACT_QUERY,  0, 0);
    send(ACT_MARK,   31, 0);
    send(ACT_REPLAY, 8, PosMax);
    send(ACT_SYNC,   63, 0);
    send(ACT_MARK,   7, 0);
    // zero count rejects every index and the query finds nothing
    write_count(0);
    send(ACT_MARK,   0, 0);
    send(ACT_QUERY,  0, 0);
    // single entry
    write_count(1);
    send(ACT_MARK,   1, 0);
    send(ACT_MARK,   0, 0);
    // count beyond the table saturates
    write_count(127);
    send(ACT_QUERY,  0, 0);
    send(ACT_MARK,   63, 0);

    // random phases at several counts; no gaps in the last one
    phase_count = '{7'd64, 7'd1, CfgW'($urandom_range(2, 63)), 7'd127, 7'd0,
                    CfgW'($urandom_range(65, 126)), CfgW'($urandom_range(2, 63)), 7'd64};
    for (int p = 0; p < 8; p++) begin
      write_count(phase_count[p]);
      gaps_on     = (p != 7);
      phase_items = (phase_count[p] == 0) ? 25 : 125;
      repeat (phase_items) send(pick_action(), pick_index(), pick_position());
    end

    // drain
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* dirty_entry_position_table.f */
rtl/core/dept_pkg.sv
rtl/core/dirty_entry_position_table.sv
tb/sv/tb_dirty_entry_position_table.sv
